### rtl/mvpm_pkg.sv
// Shared types, constants and operation codes of the PCM voice mixer.
package mvpm_pkg;

    localparam int VOICE_COUNT_DEF      = 16;
    localparam int SOUND_COUNT_DEF      = 16;
    localparam int SAMPLE_ADDR_BITS_DEF = 16;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    // Fraction bits of the unsigned Q2.14 gain
    localparam int GAIN_FRAC = 14;

    typedef enum logic [2:0] {
        OP_WRITE_SAMPLE = 3'd0,
        OP_SET_SOUND    = 3'd1,
        OP_PLAY         = 3'd2,
        OP_STOP_VOICE   = 3'd3,
        OP_STOP_ALL     = 3'd4,
        OP_SET_VOLUME   = 3'd5,
        OP_FRAME        = 3'd6
    } t_op;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] length;
    } t_sound;

    typedef struct packed {
        logic        repeat_on;
        logic [15:0] gain;
        logic [15:0] start;
        logic [16:0] length;
        logic [16:0] position;
    } t_voice;

endpackage

### rtl/mvpm_if.sv
// Valid/ready channel interfaces for mixer commands and mixer results.
interface mvpm_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [3:0]         sound_number;
    logic [15:0]        sound_start;
    logic [16:0]        sound_length;
    logic [3:0]         voice_number;
    logic [15:0]        gain;
    logic               repeat_req;

    modport source (
        output valid, operation, sample_address, sample_value, sound_number,
               sound_start, sound_length, voice_number, gain, repeat_req,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_address, sample_value, sound_number,
               sound_start, sound_length, voice_number, gain, repeat_req,
        output ready
    );
endinterface

interface mvpm_out_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [3:0]         assigned_voice;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (
        output valid, accepted, assigned_voice, left_out, right_out,
        input  ready
    );
    modport sink (
        input  valid, accepted, assigned_voice, left_out, right_out,
        output ready
    );
endinterface

### rtl/mvpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/multi_voice_pcm_mixer_core.sv
// Multi-voice PCM sample mixer: sample store, sound bank, voice table, frame render.
//
// One command item is taken at a time; the input is not ready until its result has been
// handed to the output register, which may still hold the previous result. Set volume
// does a read-modify-write of the voice table. Play reads the sound bank, then scans the
// voice table for the lowest free slot. A frame tick walks the voice table once: an
// inactive voice is skipped, a one-shot voice that has ended is dropped, and a voice that
// renders takes a voice word read, two sample store reads through its single read port
// (only one is used when one word is left, and it goes to both sides) and two passes
// through the one shared 16x17 multiplier. The sound bank and the voice table
// sit in RAMs; bank entries carry valid bits so an undefined sound reads as empty straight
// after reset, with no clearing pass. Sums are 18 + $clog2(VOICE_COUNT + 1) bits wide and
// saturate to signed 16 bits at the end of the frame.
module multi_voice_pcm_mixer_core #(
    parameter int VOICE_COUNT      = mvpm_pkg::VOICE_COUNT_DEF,
    parameter int SOUND_COUNT      = mvpm_pkg::SOUND_COUNT_DEF,
    parameter int SAMPLE_ADDR_BITS = mvpm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvpm_in_if.sink    i_in,
    mvpm_out_if.source o_out
);

    localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VCNT_W  = $clog2(VOICE_COUNT + 1);
    localparam int VNX_W   = (VOICE_W > 4) ? VOICE_W : 4;
    localparam int SND_W   = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
    localparam int SNDX_W  = (SND_W > 4) ? SND_W : 4;
    localparam int AB      = SAMPLE_ADDR_BITS;
    localparam int SADX_W  = (AB > 18) ? AB : 18;
    localparam int SCL_W   = 18;
    localparam int SUM_W   = SCL_W + VCNT_W;
    localparam int VW_W    = $bits(mvpm_pkg::t_voice);
    localparam int SW_W    = $bits(mvpm_pkg::t_sound);

    localparam logic [VCNT_W-1:0]       VOICE_END = VCNT_W'(VOICE_COUNT);
    localparam logic signed [SUM_W-1:0] SUM_MAX   = SUM_W'(mvpm_pkg::SAT_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN   = SUM_W'(mvpm_pkg::SAT_MIN);
    localparam logic signed [32:0]      ROUND_ADJ = 33'((1 << mvpm_pkg::GAIN_FRAC) - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PLAY_BANK,
        S_PLAY_SCAN,
        S_VOL_RD,
        S_VOL_WR,
        S_F_CHK,
        S_F_VOICE,
        S_F_RDL,
        S_F_GETL,
        S_F_GETR,
        S_F_MULL,
        S_F_MULR,
        S_F_ACCR,
        S_DONE
    } t_state;

    t_state r_state;

    // Latched command
    mvpm_pkg::t_op      r_op;
    logic [15:0]        r_sample_address;
    logic signed [15:0] r_sample_value;
    logic [3:0]         r_sound_number;
    logic [15:0]        r_sound_start;
    logic [16:0]        r_sound_length;
    logic [3:0]         r_voice_number;
    logic [15:0]        r_gain;
    logic               r_repeat_req;

    // Control state
    logic [VOICE_COUNT-1:0] r_active;
    logic [SOUND_COUNT-1:0] r_bank_vld;
    logic [VCNT_W-1:0]      r_idx;

    // Work registers
    logic [15:0]             r_snd_start;
    logic [16:0]             r_snd_len;
    mvpm_pkg::t_voice        r_vw;
    logic [16:0]             r_pos;
    logic [AB-1:0]           r_saddr;
    logic signed [15:0]      r_sl;
    logic signed [15:0]      r_sr;
    logic signed [32:0]      r_prod;
    logic signed [SUM_W-1:0] r_lsum;
    logic signed [SUM_W-1:0] r_rsum;

    // Result being built, and the output register
    logic               r_res_acc;
    logic [3:0]         r_res_slot;
    logic signed [15:0] r_res_left;
    logic signed [15:0] r_res_right;
    logic               r_o_valid;
    logic               r_o_acc;
    logic [3:0]         r_o_slot;
    logic signed [15:0] r_o_left;
    logic signed [15:0] r_o_right;

    // Index decode
    logic [SNDX_W-1:0] snd_ext;
    logic [SND_W-1:0]  snd_idx;
    logic              snd_ok;
    logic [VNX_W-1:0]  vn_ext;
    logic [VOICE_W-1:0] vn_idx;
    logic              vn_ok;
    logic [VOICE_W-1:0] vidx;
    logic [VNX_W-1:0]  vidx_ext;
    logic [VCNT_W-1:0] idx_next;

    assign snd_ext  = SNDX_W'(r_sound_number);
    assign snd_idx  = snd_ext[SND_W-1:0];
    assign snd_ok   = 32'(r_sound_number) < 32'(SOUND_COUNT);
    assign vn_ext   = VNX_W'(r_voice_number);
    assign vn_idx   = vn_ext[VOICE_W-1:0];
    assign vn_ok    = 32'(r_voice_number) < 32'(VOICE_COUNT);
    assign vidx     = r_idx[VOICE_W-1:0];
    assign vidx_ext = VNX_W'(vidx);
    assign idx_next = r_idx + 1'b1;

    // Memories
    logic             sample_we;
    logic [SADX_W-1:0] saddr_w_ext;
    logic [AB-1:0]    sample_waddr;
    logic [15:0]      sample_rdata;
    logic             bank_we;
    logic [SW_W-1:0]  bank_rdata;
    mvpm_pkg::t_sound bank_wdata;
    mvpm_pkg::t_sound bank_rd;
    logic             voice_we;
    mvpm_pkg::t_voice voice_wdata;
    mvpm_pkg::t_voice voice_rd;
    logic [VW_W-1:0]  voice_rdata;

    assign saddr_w_ext = SADX_W'(r_sample_address);
    assign sample_waddr = saddr_w_ext[AB-1:0];
    assign bank_rd     = mvpm_pkg::t_sound'(bank_rdata);
    assign voice_rd    = mvpm_pkg::t_voice'(voice_rdata);
    assign bank_wdata  = '{start: r_sound_start, length: r_sound_length};

    mvpm_ram #(.WIDTH(16), .DEPTH(2 ** AB)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (sample_we),
        .i_waddr (sample_waddr),
        .i_wdata (r_sample_value),
        .i_raddr (r_saddr),
        .o_rdata (sample_rdata)
    );

    mvpm_ram #(.WIDTH(SW_W), .DEPTH(SOUND_COUNT)) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr (snd_idx),
        .i_wdata (bank_wdata),
        .i_raddr (snd_idx),
        .o_rdata (bank_rdata)
    );

    mvpm_ram #(.WIDTH(VW_W), .DEPTH(VOICE_COUNT)) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (voice_we),
        .i_waddr (vidx),
        .i_wdata (voice_wdata),
        .i_raddr (vidx),
        .o_rdata (voice_rdata)
    );

    // Voice word seen at the frame check: wrap or end, and first sample address
    logic              voice_at_end;
    logic [16:0]       pos_eff;
    logic [SADX_W-1:0] saddr_sum;

    assign voice_at_end = voice_rd.position >= voice_rd.length;
    assign pos_eff      = voice_at_end ? 17'd0 : voice_rd.position;
    assign saddr_sum    = SADX_W'(voice_rd.start) + SADX_W'(pos_eff);

    // Shared multiplier: left sample first, then right
    logic signed [15:0] mul_a;
    logic signed [32:0] mul_p;
    logic signed [32:0] prod_adj;
    logic signed [32:0] prod_shr;
    logic signed [SUM_W-1:0] scaled;

    assign mul_a    = (r_state == S_F_MULR) ? r_sr : r_sl;
    assign mul_p    = mul_a * $signed({1'b0, r_vw.gain});
    // Bias negative products so the shift truncates toward zero
    assign prod_adj = r_prod + (r_prod[32] ? ROUND_ADJ : 33'sd0);
    assign prod_shr = prod_adj >>> mvpm_pkg::GAIN_FRAC;
    assign scaled   = {{(SUM_W - SCL_W){prod_shr[SCL_W-1]}}, prod_shr[SCL_W-1:0]};

    logic signed [15:0] sat_left;
    logic signed [15:0] sat_right;

    always_comb begin
        if (r_lsum > SUM_MAX) begin
            sat_left = SUM_MAX[15:0];
        end else if (r_lsum < SUM_MIN) begin
            sat_left = SUM_MIN[15:0];
        end else begin
            sat_left = r_lsum[15:0];
        end
        if (r_rsum > SUM_MAX) begin
            sat_right = SUM_MAX[15:0];
        end else if (r_rsum < SUM_MIN) begin
            sat_right = SUM_MIN[15:0];
        end else begin
            sat_right = r_rsum[15:0];
        end
    end

    // Memory write strobes and data
    always_comb begin
        sample_we   = (r_state == S_EXEC) && (r_op == mvpm_pkg::OP_WRITE_SAMPLE);
        bank_we     = (r_state == S_EXEC) && (r_op == mvpm_pkg::OP_SET_SOUND) && snd_ok;
        voice_we    = 1'b0;
        voice_wdata = r_vw;
        case (r_state)
            S_PLAY_SCAN: begin
                voice_we    = (r_idx != VOICE_END) && !r_active[vidx];
                voice_wdata = '{repeat_on: r_repeat_req, gain: r_gain, start: r_snd_start,
                                length: r_snd_len, position: 17'd0};
            end
            S_VOL_WR: begin
                voice_we         = 1'b1;
                voice_wdata      = voice_rd;
                voice_wdata.gain = r_gain;
            end
            S_F_ACCR: begin
                voice_we             = 1'b1;
                voice_wdata.position = r_pos;
            end
            default: begin
                voice_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_bank_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // the result hand-off below owns the output register while in S_DONE
            if (o_out.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op             <= mvpm_pkg::t_op'(i_in.operation);
                        r_sample_address <= i_in.sample_address;
                        r_sample_value   <= i_in.sample_value;
                        r_sound_number   <= i_in.sound_number;
                        r_sound_start    <= i_in.sound_start;
                        r_sound_length   <= i_in.sound_length;
                        r_voice_number   <= i_in.voice_number;
                        r_gain           <= i_in.gain;
                        r_repeat_req     <= i_in.repeat_req;
                        r_state          <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_acc   <= (r_op != mvpm_pkg::OP_PLAY);
                    r_res_slot  <= 4'd0;
                    r_res_left  <= 16'sd0;
                    r_res_right <= 16'sd0;
                    unique case (r_op)
                        mvpm_pkg::OP_SET_SOUND: begin
                            if (snd_ok) begin
                                r_bank_vld[snd_idx] <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        mvpm_pkg::OP_PLAY: begin
                            // bank read is under way at the sound index
                            r_state <= snd_ok ? S_PLAY_BANK : S_DONE;
                        end
                        mvpm_pkg::OP_STOP_VOICE: begin
                            if (vn_ok) begin
                                r_active[vn_idx] <= 1'b0;
                            end
                            r_state <= S_DONE;
                        end
                        mvpm_pkg::OP_STOP_ALL: begin
                            r_active <= '0;
                            r_state  <= S_DONE;
                        end
                        mvpm_pkg::OP_SET_VOLUME: begin
                            if (vn_ok && r_active[vn_idx]) begin
                                r_idx   <= VCNT_W'(r_voice_number);
                                r_state <= S_VOL_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        mvpm_pkg::OP_FRAME: begin
                            r_idx   <= '0;
                            r_lsum  <= '0;
                            r_rsum  <= '0;
                            r_state <= S_F_CHK;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_PLAY_BANK: begin
                    // an entry never set reads as empty
                    r_snd_start <= r_bank_vld[snd_idx] ? bank_rd.start : 16'd0;
                    r_snd_len   <= r_bank_vld[snd_idx] ? bank_rd.length : 17'd0;
                    r_idx       <= '0;
                    if (r_bank_vld[snd_idx] && (bank_rd.length != 17'd0)) begin
                        r_state <= S_PLAY_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PLAY_SCAN: begin
                    if (r_idx == VOICE_END) begin
                        r_state <= S_DONE;
                    end else if (!r_active[vidx]) begin
                        r_active[vidx] <= 1'b1;
                        r_res_acc      <= 1'b1;
                        r_res_slot     <= vidx_ext[3:0];
                        r_state        <= S_DONE;
                    end else begin
                        r_idx <= idx_next;
                    end
                end
                S_VOL_RD: begin
                    r_state <= S_VOL_WR;
                end
                S_VOL_WR: begin
                    r_state <= S_DONE;
                end
                S_F_CHK: begin
                    if (r_idx == VOICE_END) begin
                        r_res_left  <= sat_left;
                        r_res_right <= sat_right;
                        r_state     <= S_DONE;
                    end else if (!r_active[vidx]) begin
                        r_idx <= idx_next;
                    end else begin
                        r_state <= S_F_VOICE;
                    end
                end
                S_F_VOICE: begin
                    r_vw    <= voice_rd;
                    r_pos   <= pos_eff;
                    r_saddr <= saddr_sum[AB-1:0];
                    if (voice_at_end && !voice_rd.repeat_on) begin
                        // one-shot sound finished: drop the voice, no contribution
                        r_active[vidx] <= 1'b0;
                        r_idx          <= idx_next;
                        r_state        <= S_F_CHK;
                    end else begin
                        r_state <= S_F_RDL;
                    end
                end
                S_F_RDL: begin
                    r_saddr <= r_saddr + 1'b1;
                    r_pos   <= r_pos + 17'd1;
                    r_state <= S_F_GETL;
                end
                S_F_GETL: begin
                    r_sl <= sample_rdata;
                    if (r_pos < r_vw.length) begin
                        r_pos   <= r_pos + 17'd1;
                        r_state <= S_F_GETR;
                    end else begin
                        // single word left: repeat it on the right
                        r_sr    <= sample_rdata;
                        r_state <= S_F_MULL;
                    end
                end
                S_F_GETR: begin
                    r_sr    <= sample_rdata;
                    r_state <= S_F_MULL;
                end
                S_F_MULL: begin
                    r_prod  <= mul_p;
                    r_state <= S_F_MULR;
                end
                S_F_MULR: begin
                    r_lsum  <= r_lsum + scaled;
                    r_prod  <= mul_p;
                    r_state <= S_F_ACCR;
                end
                S_F_ACCR: begin
                    r_rsum  <= r_rsum + scaled;
                    r_idx   <= idx_next;
                    r_state <= S_F_CHK;
                end
                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_acc   <= r_res_acc;
                        r_o_slot  <= r_res_slot;
                        r_o_left  <= r_res_left;
                        r_o_right <= r_res_right;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.accepted       = r_o_acc;
    assign o_out.assigned_voice = r_o_slot;
    assign o_out.left_out       = r_o_left;
    assign o_out.right_out      = r_o_right;

endmodule

### rtl/mvpm_checker.sv
// Port-level checks of the mixer, bound to the mixer core.
module mvpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_accepted,
    input logic [3:0]  i_assigned_voice,
    input logic [15:0] i_left_out,
    input logic [15:0] i_right_out
);

    // A result waiting on the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // One command at a time: accepting an item closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    // A refused play carries no slot and no mix
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_accepted |->
            (i_assigned_voice == 4'd0) && (i_left_out == 16'd0) && (i_right_out == 16'd0))
        else $error("refused item carries a slot or mix value");

    // A nonzero slot is only given by a started voice
    a_slot_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_assigned_voice != 4'd0) |-> i_accepted)
        else $error("slot reported without a started voice");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind multi_voice_pcm_mixer_core mvpm_checker u_mvpm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_accepted       (o_out.accepted),
    .i_assigned_voice (o_out.assigned_voice),
    .i_left_out       (o_out.left_out),
    .i_right_out      (o_out.right_out)
);
